[hdl/ufs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufs_pkg
// Shared types and constants of the URL field splitter: phase codes, byte
// roles, character codes, the byte class and the result item.
// ----------------------------------------------------------------------------
package ufs_pkg;

  localparam int PHASE_W = 3;

  localparam logic [PHASE_W-1:0] PH_SCHEME = 3'd0;
  localparam logic [PHASE_W-1:0] PH_COLON  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_SLASH  = 3'd2;
  localparam logic [PHASE_W-1:0] PH_HOST   = 3'd3;
  localparam logic [PHASE_W-1:0] PH_PORT   = 3'd4;
  localparam logic [PHASE_W-1:0] PH_PATH   = 3'd5;
  localparam logic [PHASE_W-1:0] PH_REJECT = 3'd6;

  localparam int ROLE_W = 3;

  localparam logic [ROLE_W-1:0] ROLE_SCHEME = 3'd0;
  localparam logic [ROLE_W-1:0] ROLE_SEP    = 3'd1;
  localparam logic [ROLE_W-1:0] ROLE_HOST   = 3'd2;
  localparam logic [ROLE_W-1:0] ROLE_PORT   = 3'd3;
  localparam logic [ROLE_W-1:0] ROLE_PATH   = 3'd4;
  localparam logic [ROLE_W-1:0] ROLE_REJECT = 3'd5;

  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  // fixed widths of the result fields
  localparam int PORT_NUM_W   = 17;
  localparam int SCHEME_LEN_W = 3;
  localparam int HOST_LEN_W   = 7;
  localparam int PATH_LEN_W   = 8;

  typedef struct packed {
    logic       is_lower;
    logic       is_digit;
    logic       is_host;
    logic       is_colon;
    logic       is_slash;
    logic       is_nul;
    logic [3:0] digit_val;
  } char_class_t;

  typedef struct packed {
    logic [ROLE_W-1:0]       byte_role;
    logic                    done_res;
    logic                    status;
    logic                    port_present;
    logic [PORT_NUM_W-1:0]   port_number;
    logic [SCHEME_LEN_W-1:0] scheme_length;
    logic [HOST_LEN_W-1:0]   host_length;
    logic [PATH_LEN_W-1:0]   path_length;
  } result_t;

endpackage

[hdl/ufs_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufs_in_if
// Byte channel into the URL field splitter: valid/ready plus one URL byte.
// ----------------------------------------------------------------------------
interface ufs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] url_byte;
  logic       last_byte;

  modport source (output valid, output url_byte, output last_byte, input ready);
  modport sink   (input valid, input url_byte, input last_byte, output ready);
endinterface

[hdl/ufs_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufs_out_if
// Result channel of the URL field splitter: valid/ready plus the byte role
// and, on the final byte, the match report.
// ----------------------------------------------------------------------------
interface ufs_out_if;
  logic                               valid;
  logic                               ready;
  logic [ufs_pkg::ROLE_W-1:0]         byte_role;
  logic                               done_res;
  logic                               status;
  logic                               port_present;
  logic [ufs_pkg::PORT_NUM_W-1:0]     port_number;
  logic [ufs_pkg::SCHEME_LEN_W-1:0]   scheme_length;
  logic [ufs_pkg::HOST_LEN_W-1:0]     host_length;
  logic [ufs_pkg::PATH_LEN_W-1:0]     path_length;

  modport source (output valid, output byte_role, output done_res, output status,
                  output port_present, output port_number, output scheme_length,
                  output host_length, output path_length, input ready);
  modport sink   (input valid, input byte_role, input done_res, input status,
                  input port_present, input port_number, input scheme_length,
                  input host_length, input path_length, output ready);
endinterface

[hdl/url_field_splitter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// url_field_splitter
// Byte-serial checker for scheme://host[:port]/path with field lengths and
// decimal port value reported on the final byte.
// ----------------------------------------------------------------------------
// Takes one URL byte per cycle while the output is not stalled and returns
// one result item per byte, passing the input register and then the result
// register. The rate is one item per clock when not stalled, set by the
// update of the phase machine and its counters between those registers. The
// item flagged last_byte carries match status, port presence and value and
// the scheme, host and path lengths; all parsing state then returns to its
// reset value for the next URL. in_ch.ready stays high while the output
// register is free or being emptied.
module url_field_splitter #(
  parameter int SCHEME_MAX    = 7,
  parameter int HOST_MAX      = 127,
  parameter int PORT_DIGITS   = 5,
  parameter int PATH_TAIL_MAX = 254
) (
  input  logic        clk,
  input  logic        rst_n,
  ufs_in_if.sink      in_ch,
  ufs_out_if.source   out_ch
);

  logic                 in_valid_r;
  logic [7:0]           in_byte_r;
  logic                 in_last_r;
  logic                 out_valid_r;
  logic                 advance;
  logic                 in_take;
  logic                 step;
  ufs_pkg::char_class_t cls;
  ufs_pkg::result_t     res_r;

  assign advance     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !in_valid_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;
  assign step        = in_valid_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_ch.url_byte;
      in_last_r <= in_ch.last_byte;
    end
  end

  ufs_char_class u_char_class (
    .url_byte (in_byte_r),
    .cls      (cls)
  );

  ufs_parse_core #(
    .SCHEME_MAX    (SCHEME_MAX),
    .HOST_MAX      (HOST_MAX),
    .PORT_DIGITS   (PORT_DIGITS),
    .PATH_TAIL_MAX (PATH_TAIL_MAX)
  ) u_parse_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .cls       (cls),
    .last_byte (in_last_r),
    .res_r     (res_r)
  );

  assign out_ch.valid         = out_valid_r;
  assign out_ch.byte_role     = res_r.byte_role;
  assign out_ch.done_res      = res_r.done_res;
  assign out_ch.status        = res_r.status;
  assign out_ch.port_present  = res_r.port_present;
  assign out_ch.port_number   = res_r.port_number;
  assign out_ch.scheme_length = res_r.scheme_length;
  assign out_ch.host_length   = res_r.host_length;
  assign out_ch.path_length   = res_r.path_length;

endmodule

[hdl/ufs_char_class.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufs_char_class
// Classifies one URL byte: lower-case letter, digit, host character,
// colon, slash, zero byte, and the digit's value.
// ----------------------------------------------------------------------------
module ufs_char_class (
  input  logic [7:0]           url_byte,
  output ufs_pkg::char_class_t cls
);

  logic [7:0] digit_off;

  assign digit_off = url_byte - ufs_pkg::CH_ZERO;

  always_comb begin
    cls.is_lower  = url_byte inside {[8'h61:8'h7a]};
    cls.is_digit  = url_byte inside {[8'h30:8'h39]};
    cls.is_host   = cls.is_lower || cls.is_digit ||
                    (url_byte inside {[8'h41:8'h5a]}) ||
                    (url_byte == ufs_pkg::CH_DOT);
    cls.is_colon  = (url_byte == ufs_pkg::CH_COLON);
    cls.is_slash  = (url_byte == ufs_pkg::CH_SLASH);
    cls.is_nul    = (url_byte == 8'h00);
    cls.digit_val = digit_off[3:0];
  end

endmodule

[hdl/ufs_parse_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufs_parse_core
// Phase machine and field counters. On each step it classifies the byte's
// role, updates the counters and registers the result item.
// ----------------------------------------------------------------------------
module ufs_parse_core #(
  parameter int SCHEME_MAX    = 7,
  parameter int HOST_MAX      = 127,
  parameter int PORT_DIGITS   = 5,
  parameter int PATH_TAIL_MAX = 254
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  ufs_pkg::char_class_t cls,
  input  logic                 last_byte,
  output ufs_pkg::result_t     res_r
);

  localparam int SCH_W  = $clog2(SCHEME_MAX + 1);
  localparam int HOST_W = $clog2(HOST_MAX + 1);
  localparam int PDIG_W = $clog2(PORT_DIGITS + 1);
  localparam int PATH_W = $clog2(PATH_TAIL_MAX + 2);
  localparam int ACC_W  = ufs_pkg::PORT_NUM_W;

  logic [ufs_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic [SCH_W-1:0]            scheme_cnt_r, scheme_cnt_nxt;
  logic [HOST_W-1:0]           host_cnt_r, host_cnt_nxt;
  logic [PDIG_W-1:0]           pdig_cnt_r, pdig_cnt_nxt;
  logic [PATH_W-1:0]           path_cnt_r, path_cnt_nxt;
  logic [ACC_W-1:0]            port_acc_r, port_acc_nxt;
  logic [ACC_W-1:0]            acc_times10;
  logic [ufs_pkg::ROLE_W-1:0]  role;
  logic                        ok;
  ufs_pkg::result_t            res_nxt;

  // acc * 10 as two shifts
  assign acc_times10 = {port_acc_r[ACC_W-4:0], 3'b000} + {port_acc_r[ACC_W-2:0], 1'b0};

  always_comb begin
    phase_nxt      = phase_r;
    scheme_cnt_nxt = scheme_cnt_r;
    host_cnt_nxt   = host_cnt_r;
    pdig_cnt_nxt   = pdig_cnt_r;
    path_cnt_nxt   = path_cnt_r;
    port_acc_nxt   = port_acc_r;
    role           = ufs_pkg::ROLE_REJECT;
    ok             = 1'b0;

    case (phase_r)
      ufs_pkg::PH_SCHEME: begin
        if (cls.is_lower && scheme_cnt_r < SCH_W'(SCHEME_MAX)) begin
          scheme_cnt_nxt = scheme_cnt_r + SCH_W'(1);
          role = ufs_pkg::ROLE_SCHEME;
          ok   = 1'b1;
        end else if (cls.is_colon && scheme_cnt_r != '0) begin
          phase_nxt = ufs_pkg::PH_COLON;
          role = ufs_pkg::ROLE_SEP;
          ok   = 1'b1;
        end
      end
      ufs_pkg::PH_COLON: begin
        if (cls.is_slash) begin
          phase_nxt = ufs_pkg::PH_SLASH;
          role = ufs_pkg::ROLE_SEP;
          ok   = 1'b1;
        end
      end
      ufs_pkg::PH_SLASH: begin
        if (cls.is_slash) begin
          phase_nxt = ufs_pkg::PH_HOST;
          role = ufs_pkg::ROLE_SEP;
          ok   = 1'b1;
        end
      end
      ufs_pkg::PH_HOST: begin
        if (cls.is_host) begin
          if (host_cnt_r < HOST_W'(HOST_MAX)) begin
            host_cnt_nxt = host_cnt_r + HOST_W'(1);
            role = ufs_pkg::ROLE_HOST;
            ok   = 1'b1;
          end
        end else if (host_cnt_r != '0) begin
          if (cls.is_colon) begin
            phase_nxt = ufs_pkg::PH_PORT;
            role = ufs_pkg::ROLE_SEP;
            ok   = 1'b1;
          end else if (cls.is_slash) begin
            phase_nxt    = ufs_pkg::PH_PATH;
            path_cnt_nxt = PATH_W'(1);
            role = ufs_pkg::ROLE_PATH;
            ok   = 1'b1;
          end
        end
      end
      ufs_pkg::PH_PORT: begin
        if (cls.is_digit && pdig_cnt_r < PDIG_W'(PORT_DIGITS)) begin
          pdig_cnt_nxt = pdig_cnt_r + PDIG_W'(1);
          port_acc_nxt = acc_times10 + ACC_W'(cls.digit_val);
          role = ufs_pkg::ROLE_PORT;
          ok   = 1'b1;
        end else if (cls.is_slash) begin
          phase_nxt    = ufs_pkg::PH_PATH;
          path_cnt_nxt = PATH_W'(1);
          role = ufs_pkg::ROLE_PATH;
          ok   = 1'b1;
        end
      end
      ufs_pkg::PH_PATH: begin
        if (!cls.is_nul && path_cnt_r < PATH_W'(PATH_TAIL_MAX + 1)) begin
          path_cnt_nxt = path_cnt_r + PATH_W'(1);
          role = ufs_pkg::ROLE_PATH;
          ok   = 1'b1;
        end
      end
      default: begin
        ok = 1'b0;
      end
    endcase

    if (!ok) begin
      phase_nxt = ufs_pkg::PH_REJECT;
    end

    res_nxt           = '0;
    res_nxt.byte_role = role;
    if (last_byte) begin
      res_nxt.done_res = 1'b1;
      if (phase_nxt == ufs_pkg::PH_PATH) begin
        res_nxt.port_present  = (pdig_cnt_nxt != '0);
        res_nxt.port_number   = port_acc_nxt;
        res_nxt.scheme_length = ufs_pkg::SCHEME_LEN_W'(scheme_cnt_nxt);
        res_nxt.host_length   = ufs_pkg::HOST_LEN_W'(host_cnt_nxt);
        res_nxt.path_length   = ufs_pkg::PATH_LEN_W'(path_cnt_nxt);
      end else begin
        res_nxt.status = 1'b1;
      end
      // URL closed: back to the start
      phase_nxt      = ufs_pkg::PH_SCHEME;
      scheme_cnt_nxt = '0;
      host_cnt_nxt   = '0;
      pdig_cnt_nxt   = '0;
      path_cnt_nxt   = '0;
      port_acc_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= ufs_pkg::PH_SCHEME;
      scheme_cnt_r <= '0;
      host_cnt_r   <= '0;
      pdig_cnt_r   <= '0;
      path_cnt_r   <= '0;
      port_acc_r   <= '0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      scheme_cnt_r <= scheme_cnt_nxt;
      host_cnt_r   <= host_cnt_nxt;
      pdig_cnt_r   <= pdig_cnt_nxt;
      path_cnt_r   <= path_cnt_nxt;
      port_acc_r   <= port_acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res_nxt;
    end
  end

endmodule
